// File: hw/rtl/text_console_cursor_scroll_core_assert.svh
// Assertion macros used by the console checker.
// Clocked assertion that is switched off while reset is high.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_CORE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_CORE_ASSERT_SVH
`define TCCS_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define TCCS_ASSERT_ALL(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: hw/rtl/tccs_pkg.sv
// ----------------------------------------------------------------------------
// tccs_pkg
// Types and fixed constants of the text console engine: command codes,
// control characters, transfer payloads and the queue entry.
// ----------------------------------------------------------------------------
package tccs_pkg;

   // widest cursor fields over the supported screen sizes
   localparam int MAX_ROW_W   = 6;
   localparam int MAX_COL_W   = 8;
   localparam int POS_W       = 11;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   localparam logic [7:0]  RESET_ATTR   = 8'h0F;
   localparam logic [15:0] RESET_CELL   = 16'h0F00;
   localparam logic [7:0]  BLANK_CHAR   = 8'h00;
   localparam logic [7:0]  CH_NEWLINE   = 8'd10;
   localparam logic [7:0]  CH_RETURN    = 8'd13;
   localparam logic [7:0]  CH_BACKSPACE = 8'd8;

   typedef enum logic [1:0] {
      CMD_PUT   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_SET   = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] char_code;
      logic [6:0] col;
      logic [4:0] row;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0] cursor_position;
      logic [15:0]      cell_data;
   } rsp_type;

   // one classified command, handed from the front to the back
   typedef struct packed {
      logic                 write_en;
      logic                 read_en;
      logic                 scroll;
      logic                 clear;
      logic [7:0]           attr;
      logic [15:0]          wdata;
      logic [MAX_ROW_W-1:0] acc_row;
      logic [MAX_COL_W-1:0] acc_col;
      logic [MAX_ROW_W-1:0] cur_row;
      logic [MAX_COL_W-1:0] cur_col;
   } entry_type;

endpackage

// File: hw/rtl/text_console_cursor_scroll_core.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_core
// Text console engine: screen of attribute/character cells with a cursor,
// put char with newline, return, backspace, wrap and scroll, plus clear,
// set cursor and cell read.
//
//   channel   ports                           transfer when
//   request   start, busy, req_data           start && !busy
//   result    rsp_valid, rsp_data             rsp_valid (one cycle)
//   attribute csr_valid, csr_ready, csr_data  csr_valid && csr_ready
//
// A command passes the screen engine through a queue pop and a cell access;
// a cell read adds a registered memory read. A scroll blanks one row and
// clear blanks every cell, one cell per cycle.
// After reset a clearing pass over every cell holds busy high.
// A four-entry queue lets commands enter while the engine sweeps; busy
// rises when it is full. Results are never held off.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_core #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tccs_pkg::req_type req_data,
   output logic              rsp_valid,
   output tccs_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_data
);

   logic                accept;
   logic [7:0]          attr_ff;
   tccs_pkg::entry_type front_entry, q_entry;
   logic                q_full, q_valid, q_pop, init_active;

   assign busy      = reset || init_active || q_full;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // hold the text attribute
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= tccs_pkg::RESET_ATTR;
      end else if (csr_valid && csr_ready) begin
         attr_ff <= csr_data;
      end
   end

   tccs_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .attr   (attr_ff),
      .entry  (front_entry)
   );

   tccs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_entry (front_entry),
      .full       (q_full),
      .pop        (q_pop),
      .valid      (q_valid),
      .pop_entry  (q_entry)
   );

   tccs_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_pop       (q_pop),
      .init_active (init_active),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

// File: hw/rtl/tccs_front.sv
// ----------------------------------------------------------------------------
// tccs_front
// Cursor tracker: takes each command, updates the cursor and turns the
// command into one queue entry (cell write, read, scroll, clear).
// ----------------------------------------------------------------------------
module tccs_front #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  tccs_pkg::req_type   req,
   input  logic [7:0]          attr,
   output tccs_pkg::entry_type entry
);

   localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             row_step;

   // classify the command and work out the next cursor
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      row_step = 1'b0;
      entry    = '0;
      entry.attr = attr;
      unique case (req.cmd)
         tccs_pkg::CMD_PUT: begin
            priority if (req.char_code == tccs_pkg::CH_NEWLINE) begin
               col_in   = '0;
               row_step = 1'b1;
            end else if (req.char_code == tccs_pkg::CH_RETURN) begin
               col_in = '0;
            end else if (req.char_code == tccs_pkg::CH_BACKSPACE) begin
               if (col_ff != '0) begin
                  col_in         = col_ff - 1'b1;
                  entry.write_en = 1'b1;
                  entry.wdata    = {attr, tccs_pkg::BLANK_CHAR};
                  entry.acc_col  = tccs_pkg::MAX_COL_W'(col_ff - 1'b1);
                  entry.acc_row  = tccs_pkg::MAX_ROW_W'(row_ff);
               end
            end else begin
               entry.write_en = 1'b1;
               entry.wdata    = {attr, req.char_code};
               entry.acc_col  = tccs_pkg::MAX_COL_W'(col_ff);
               entry.acc_row  = tccs_pkg::MAX_ROW_W'(row_ff);
               if (col_ff == COL_W'(COLUMNS - 1)) begin
                  col_in   = '0;
                  row_step = 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
            // past the last row: scroll and stay on it
            if (row_step) begin
               if (row_ff == ROW_W'(ROWS - 1)) begin
                  entry.scroll = 1'b1;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end
         end
         tccs_pkg::CMD_CLEAR: begin
            entry.clear = 1'b1;
            col_in      = '0;
            row_in      = '0;
         end
         tccs_pkg::CMD_SET: begin
            col_in = (int'(req.col) < COLUMNS) ? COL_W'(req.col) : COL_W'(COLUMNS - 1);
            row_in = (int'(req.row) < ROWS) ? ROW_W'(req.row) : ROW_W'(ROWS - 1);
         end
         tccs_pkg::CMD_READ: begin
            if (int'(req.col) < COLUMNS && int'(req.row) < ROWS) begin
               entry.read_en = 1'b1;
               entry.acc_col = tccs_pkg::MAX_COL_W'(req.col);
               entry.acc_row = tccs_pkg::MAX_ROW_W'(req.row);
            end
         end
         default: begin
         end
      endcase
      entry.cur_col = tccs_pkg::MAX_COL_W'(col_in);
      entry.cur_row = tccs_pkg::MAX_ROW_W'(row_in);
   end

   // advance the cursor on each accepted command
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// File: hw/rtl/tccs_queue.sv
// ----------------------------------------------------------------------------
// tccs_queue
// Short first-in first-out queue of classified commands between the
// cursor tracker and the screen engine.
// ----------------------------------------------------------------------------
module tccs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tccs_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                valid,
   output tccs_pkg::entry_type pop_entry
);

   localparam int CNT_W = tccs_pkg::QUEUE_PTR_W + 1;

   tccs_pkg::entry_type                  slot_ff [tccs_pkg::QUEUE_DEPTH];
   logic [tccs_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]                     count_ff, count_in;

   assign full      = (count_ff == CNT_W'(tccs_pkg::QUEUE_DEPTH));
   assign valid     = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // move pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   // hold the entries
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: hw/rtl/tccs_back.sv
// ----------------------------------------------------------------------------
// tccs_back
// Screen engine: owns the cell memory, carries out queued commands and
// sends one result per command. Scrolling rotates a top-row offset and
// blanks one row; clear and the pass after reset sweep every cell.
// ----------------------------------------------------------------------------
module tccs_back #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  tccs_pkg::entry_type q_entry,
   output logic                q_pop,
   output logic                init_active,
   output logic                rsp_valid,
   output tccs_pkg::rsp_type   rsp_data
);

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_EXEC  = 4'b0010,
      ST_READ  = 4'b0100,
      ST_SWEEP = 4'b1000
   } back_state_type;

   back_state_type      state_ff, state_in;
   tccs_pkg::entry_type cur_ff, cur_in;
   logic [ROW_W-1:0]    top_ff, top_in;
   logic [ADDR_W-1:0]   sweep_addr_ff, sweep_addr_in;
   logic [ADDR_W-1:0]   sweep_left_ff, sweep_left_in;
   logic [15:0]         fill_ff, fill_in;
   logic                emit_ff, emit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   tccs_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic [15:0]         mem_ff [CELLS];
   logic [15:0]         rd_data_ff;
   logic                mem_we, mem_re;
   logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
   logic [15:0]         mem_wdata;

   logic [ROW_W:0]      row_sum;
   logic [ROW_W-1:0]    phys_row;
   logic [ADDR_W-1:0]   acc_addr;
   logic [ADDR_W-1:0]   pos;

   // map the logical row through the top-row offset
   always_comb begin
      row_sum = (ROW_W + 1)'(cur_ff.acc_row) + (ROW_W + 1)'(top_ff);
      if (row_sum >= (ROW_W + 1)'(ROWS)) begin
         row_sum = row_sum - (ROW_W + 1)'(ROWS);
      end
      phys_row = ROW_W'(row_sum);
      acc_addr = ADDR_W'(phys_row) * ADDR_W'(COLUMNS) + ADDR_W'(cur_ff.acc_col);
      pos      = ADDR_W'(cur_ff.cur_row) * ADDR_W'(COLUMNS) + ADDR_W'(cur_ff.cur_col);
   end

   assign init_active = (state_ff == ST_SWEEP) && !emit_ff;
   assign q_pop       = (state_ff == ST_IDLE) && q_valid;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;

   // sequence the commands
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      top_in        = top_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_left_in = sweep_left_ff;
      fill_in       = fill_ff;
      emit_in       = emit_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = acc_addr;
      mem_raddr     = acc_addr;
      mem_wdata     = cur_ff.wdata;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               cur_in   = q_entry;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (cur_ff.clear) begin
               top_in        = '0;
               sweep_addr_in = '0;
               sweep_left_in = ADDR_W'(CELLS - 1);
               fill_in       = {cur_ff.attr, tccs_pkg::BLANK_CHAR};
               emit_in       = 1'b1;
               state_in      = ST_SWEEP;
            end else begin
               mem_we = cur_ff.write_en;
               if (cur_ff.read_en) begin
                  mem_re   = 1'b1;
                  state_in = ST_READ;
               end else if (cur_ff.scroll) begin
                  // old top row becomes the new bottom row
                  top_in        = (top_ff == ROW_W'(ROWS - 1)) ? '0 : top_ff + 1'b1;
                  sweep_addr_in = ADDR_W'(top_ff) * ADDR_W'(COLUMNS);
                  sweep_left_in = ADDR_W'(COLUMNS - 1);
                  fill_in       = {cur_ff.attr, tccs_pkg::BLANK_CHAR};
                  emit_in       = 1'b1;
                  state_in      = ST_SWEEP;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{cursor_position: tccs_pkg::POS_W'(pos), cell_data: '0};
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{cursor_position: tccs_pkg::POS_W'(pos), cell_data: rd_data_ff};
            state_in     = ST_IDLE;
         end
         ST_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_addr_ff;
            mem_wdata = fill_ff;
            if (sweep_left_ff == '0) begin
               rsp_valid_in = emit_ff;
               rsp_data_in  = '{cursor_position: tccs_pkg::POS_W'(pos), cell_data: '0};
               state_in     = ST_IDLE;
            end else begin
               sweep_addr_in = sweep_addr_ff + 1'b1;
               sweep_left_in = sweep_left_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers; reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         top_ff        <= '0;
         sweep_addr_ff <= '0;
         sweep_left_ff <= ADDR_W'(CELLS - 1);
         fill_ff       <= tccs_pkg::RESET_CELL;
         emit_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         top_ff        <= top_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_left_ff <= sweep_left_in;
         fill_ff       <= fill_in;
         emit_ff       <= emit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   // cell memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem_ff[mem_raddr];
      end
   end

endmodule

// File: hw/rtl/tccs_checker.sv
// ----------------------------------------------------------------------------
// tccs_checker
// Port-level checks of the console engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_console_cursor_scroll_core_assert.svh"

module tccs_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input tccs_pkg::rsp_type rsp_data
);

   // the clearing pass follows every reset
   `TCCS_ASSERT_ALL(a_busy_after_reset, clock, reset |=> busy, "no clearing pass after reset")

   // no result comes out of reset
   `TCCS_ASSERT_ALL(a_quiet_after_reset, clock, reset |=> !rsp_valid, "result right after reset")

   // the engine needs a pop cycle between results
   `TCCS_ASSERT_RST(a_result_gap, clock, reset, rsp_valid |=> !rsp_valid, "back-to-back results")

   // busy is still high as the clearing pass starts, once reset has fallen
   `TCCS_ASSERT_ALL(a_busy_hold, clock, reset ##1 !reset |-> busy, "clearing pass ended early")

endmodule

bind text_console_cursor_scroll_core tccs_checker u_checker (.*);

// File: sim/tb_text_console_cursor_scroll_core.sv
// ----------------------------------------------------------------------------
// tb_text_console_cursor_scroll_core
// Self-checking bench for the text console engine. A short directed sweep
// covers control characters, wrap, scroll, clamped set cursor and reads out
// of range; random traffic follows under four attribute settings. Every
// accepted command is run through a screen model kept here, and each result
// is compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_scroll_core;
   import tccs_pkg::*;

   localparam int COLS         = 80;
   localparam int ROWS         = 25;
   localparam int CELLS        = COLS * ROWS;
   localparam int SETTLE_CYC   = CELLS + 100;
   localparam int STALL_LIMIT  = 20000;

   logic        clock;
   logic        reset;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_data;

   // screen model
   logic [15:0] screen_model [CELLS];
   int          cur_col;
   int          cur_row;
   logic [7:0]  attr_model;

   req_type     pending_commands [$];
   rsp_type     expected_reports [$];
   rsp_type     oldest_report;
   int          gap_left;
   bit          steady_feed;
   int          fail_count;
   int          reports_checked;
   int          stall_cycles;
   int          n_put, n_clear, n_set, n_read, n_scroll, n_settings;

   text_console_cursor_scroll_core #(
      .COLUMNS (COLS),
      .ROWS    (ROWS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Fill cells from the given index to the end of the screen with blanks.
   function automatic void blank_from(int first);
      for (int i = first; i < CELLS; i++) screen_model[i] = {attr_model, BLANK_CHAR};
   endfunction

   // Apply one command to the screen model and return the result it causes.
   function automatic rsp_type console_apply(req_type cmd_in);
      rsp_type outcome;
      int      idx;
      outcome = '0;
      case (cmd_in.cmd)
         CMD_PUT: begin
            n_put++;
            if (cmd_in.char_code == CH_NEWLINE) begin
               cur_col = 0;
               cur_row++;
            end else if (cmd_in.char_code == CH_RETURN) begin
               cur_col = 0;
            end else if (cmd_in.char_code == CH_BACKSPACE) begin
               if (cur_col > 0) begin
                  cur_col--;
                  screen_model[cur_row * COLS + cur_col] = {attr_model, BLANK_CHAR};
               end
            end else begin
               screen_model[cur_row * COLS + cur_col] = {attr_model, cmd_in.char_code};
               cur_col++;
            end
            if (cur_col >= COLS) begin
               cur_col = 0;
               cur_row++;
            end
            // scroll up one row once the cursor runs off the bottom
            if (cur_row >= ROWS) begin
               n_scroll++;
               for (idx = 0; idx + COLS < CELLS; idx++)
                  screen_model[idx] = screen_model[idx + COLS];
               blank_from((ROWS - 1) * COLS);
               cur_row = ROWS - 1;
            end
         end
         CMD_CLEAR: begin
            n_clear++;
            blank_from(0);
            cur_col = 0;
            cur_row = 0;
         end
         CMD_SET: begin
            n_set++;
            cur_col = (cmd_in.col < COLS) ? int'(cmd_in.col) : COLS - 1;
            cur_row = (cmd_in.row < ROWS) ? int'(cmd_in.row) : ROWS - 1;
         end
         default: begin
            n_read++;
            if (cmd_in.col < COLS && cmd_in.row < ROWS)
               outcome.cell_data = screen_model[int'(cmd_in.row) * COLS + int'(cmd_in.col)];
         end
      endcase
      outcome.cursor_position = POS_W'(cur_row * COLS + cur_col);
      return outcome;
   endfunction

   function automatic req_type make_cmd(cmd_type c, logic [7:0] ch, logic [6:0] col,
                                        logic [4:0] row);
      req_type item;
      item.cmd       = c;
      item.char_code = ch;
      item.col       = col;
      item.row       = row;
      return item;
   endfunction

   // Mostly text with line control, cursor moves biased toward the right
   // edge and bottom rows, reads over the screen and beyond, rare clears.
   function automatic req_type random_cmd();
      req_type item;
      int      pick;
      int      sel;
      item      = '0;
      item.col  = 7'($urandom_range(0, 127));
      item.row  = 5'($urandom_range(0, 31));
      item.char_code = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
         item.cmd = CMD_PUT;
         sel = $urandom_range(0, 19);
         if (sel < 14)
            item.char_code = 8'($urandom_range(8'h20, 8'h7E));
         else if (sel == 14)
            item.char_code = CH_NEWLINE;
         else if (sel == 15)
            item.char_code = CH_RETURN;
         else if (sel == 16)
            item.char_code = CH_BACKSPACE;
      end else if (pick < 68) begin
         item.cmd = CMD_SET;
         if ($urandom_range(0, 1)) item.col = 7'($urandom_range(70, 85));
         if ($urandom_range(0, 1)) item.row = 5'($urandom_range(20, 31));
      end else if (pick < 98) begin
         item.cmd = CMD_READ;
         if ($urandom_range(0, 3) != 0) begin
            item.col = 7'($urandom_range(0, COLS - 1));
            item.row = 5'($urandom_range(ROWS - 6, ROWS - 1));
         end
      end else begin
         item.cmd = CMD_CLEAR;
      end
      return item;
   endfunction

   // Driver: present queued commands, with random idle bursts.
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         gap_left = 0;
      end else begin
         if (start && !busy)
            expected_reports.push_back(console_apply(req_data));
         if (start && busy) begin
            // hold the command until it is taken
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_commands.size() > 0 && !steady_feed &&
                      $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(0, 10);
            start <= 1'b0;
         end else if (pending_commands.size() > 0) begin
            start    <= 1'b1;
            req_data <= pending_commands.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: check every result against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_reports.size() == 0) begin
            $error("result with nothing outstanding: cursor_position %0d cell_data %h",
                   rsp_data.cursor_position, rsp_data.cell_data);
            fail_count++;
         end else begin
            oldest_report = expected_reports.pop_front();
            reports_checked++;
            if (rsp_data.cursor_position !== oldest_report.cursor_position) begin
               $error("cursor_position: expected %0d, actual %0d",
                      oldest_report.cursor_position, rsp_data.cursor_position);
               fail_count++;
            end
            if (rsp_data.cell_data !== oldest_report.cell_data) begin
               $error("cell_data: expected %h, actual %h",
                      oldest_report.cell_data, rsp_data.cell_data);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: end the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Wait until every queued command is taken and every result is back.
   task automatic wait_drained();
      @(negedge clock);
      while (pending_commands.size() > 0 || start || expected_reports.size() > 0)
         @(negedge clock);
   endtask

   // Write the attribute register while the engine is idle.
   task automatic write_attribute(input logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      attr_model = value;
      n_settings++;
   endtask

   task automatic queue_random(input int count);
      @(negedge clock);
      for (int i = 0; i < count; i++) pending_commands.push_back(random_cmd());
   endtask

   initial begin
      reset      = 1'b1;
      csr_valid  = 1'b0;
      csr_data   = '0;
      steady_feed = 1'b0;
      fail_count = 0;
      reports_checked = 0;
      n_put = 0; n_clear = 0; n_set = 0; n_read = 0; n_scroll = 0; n_settings = 0;
      for (int i = 0; i < CELLS; i++) screen_model[i] = RESET_CELL;
      cur_col    = 0;
      cur_row    = 0;
      attr_model = RESET_ATTR;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed sweep under the reset attribute
      @(negedge clock);
      pending_commands.push_back(make_cmd(CMD_PUT,   CH_BACKSPACE, 7'h7F, 5'h1F));
      pending_commands.push_back(make_cmd(CMD_PUT,   8'h41,        7'h00, 5'h00));
      pending_commands.push_back(make_cmd(CMD_PUT,   8'hFF,        7'h55, 5'h0A));
      pending_commands.push_back(make_cmd(CMD_PUT,   8'h00,        7'h2A, 5'h15));
      pending_commands.push_back(make_cmd(CMD_PUT,   CH_BACKSPACE, 7'h00, 5'h00));
      pending_commands.push_back(make_cmd(CMD_PUT,   CH_RETURN,    7'h00, 5'h00));
      pending_commands.push_back(make_cmd(CMD_PUT,   CH_NEWLINE,   7'h00, 5'h00));
      pending_commands.push_back(make_cmd(CMD_READ,  8'hFF,        7'd0,  5'd0));
      pending_commands.push_back(make_cmd(CMD_READ,  8'h00,        7'd1,  5'd0));
      pending_commands.push_back(make_cmd(CMD_SET,   8'h00,        7'h7F, 5'h1F));
      pending_commands.push_back(make_cmd(CMD_PUT,   8'h7E,        7'h00, 5'h00));
      pending_commands.push_back(make_cmd(CMD_READ,  8'h00,        7'd79, 5'd23));
      pending_commands.push_back(make_cmd(CMD_READ,  8'h00,        7'h7F, 5'h1F));
      pending_commands.push_back(make_cmd(CMD_READ,  8'h00,        7'd80, 5'd0));
      pending_commands.push_back(make_cmd(CMD_READ,  8'h00,        7'd0,  5'd25));
      pending_commands.push_back(make_cmd(CMD_PUT,   CH_NEWLINE,   7'h00, 5'h00));
      pending_commands.push_back(make_cmd(CMD_READ,  8'h00,        7'd79, 5'd22));
      pending_commands.push_back(make_cmd(CMD_CLEAR, 8'h00,        7'h00, 5'h00));
      pending_commands.push_back(make_cmd(CMD_READ,  8'h00,        7'd0,  5'd0));
      pending_commands.push_back(make_cmd(CMD_SET,   8'h00,        7'd79, 5'd0));
      pending_commands.push_back(make_cmd(CMD_PUT,   8'h5A,        7'h00, 5'h00));
      pending_commands.push_back(make_cmd(CMD_READ,  8'h00,        7'd79, 5'd0));
      pending_commands.push_back(make_cmd(CMD_SET,   8'h00,        7'd5,  5'd3));
      pending_commands.push_back(make_cmd(CMD_PUT,   CH_BACKSPACE, 7'h00, 5'h00));
      pending_commands.push_back(make_cmd(CMD_READ,  8'h00,        7'd4,  5'd3));
      wait_drained();

      // random traffic under several attribute values, extremes first
      repeat (SETTLE_CYC) @(posedge clock);
      write_attribute(8'h00);
      queue_random(150);
      wait_drained();
      repeat (SETTLE_CYC) @(posedge clock);
      write_attribute(8'hFF);
      queue_random(150);
      wait_drained();
      repeat (SETTLE_CYC) @(posedge clock);
      write_attribute(8'($urandom_range(1, 254)));
      queue_random(100);
      wait_drained();

      // closing stretch fed back to back
      repeat (SETTLE_CYC) @(posedge clock);
      write_attribute(8'hA5);
      steady_feed = 1'b1;
      queue_random(100);
      wait_drained();
      repeat (40) @(posedge clock);

      if (expected_reports.size() > 0) begin
         $error("%0d results never arrived", expected_reports.size());
         fail_count++;
      end
      $display("covered %0d puts, %0d clears, %0d cursor moves, %0d reads, %0d scrolls",
               n_put, n_clear, n_set, n_read, n_scroll);
      $display("checked %0d results across %0d attribute settings",
               reports_checked, n_settings + 1);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
